// ----- rtl/core/dts_pkg.sv -----
// Shared types, sizes and codes of the digest trie set.
`timescale 1ns / 1ps
package dts_pkg;

	localparam int DIGEST_NIBBLES = 32;
	localparam int RADIX          = 16;
	localparam int MAX_DIGESTS    = 256;

	localparam int DIGEST_W    = 128;
	localparam int NIB_W       = $clog2(RADIX);
	localparam int POOL_NODES  = MAX_DIGESTS * DIGEST_NIBBLES;
	localparam int NODE_W      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int TABLE_DEPTH = RADIX * POOL_NODES;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LVL_W       = (DIGEST_NIBBLES > 1) ? $clog2(DIGEST_NIBBLES) : 1;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic        command;
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} req_t;

	typedef struct packed {
		logic hit;
		logic status;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic eval;
		logic advance;
		logic rsp_load;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic miss;
		logic full;
		logic last_level;
		logic is_lookup;
		logic rsp_free;
	} sts_t;

endpackage

// ----- rtl/core/dts_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module dts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/dts_datapath.sv -----
// Datapath of the digest trie set: walk registers, node pool count, child table and result.
`timescale 1ns / 1ps
module dts_datapath import dts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  req_t req,
	input  logic rsp_stall,
	output sts_t sts,
	output logic rsp_valid,
	output rsp_t rsp
);

	logic [DIGEST_W-1:0] digest_q;
	logic                cmd_q;
	logic [NODE_W-1:0]   cur_q;
	logic [NODE_W-1:0]   used_q;
	logic [LVL_W-1:0]    level_q;
	logic                hit_q;
	logic                status_q;
	logic [ADDR_W-1:0]   clr_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [NIB_W-1:0]  nib;
	logic [ADDR_W-1:0] walk_addr;
	logic [ADDR_W-1:0] ram_addr;
	logic [NODE_W-1:0] ram_wdata;
	logic [NODE_W-1:0] ram_rdata;
	logic [NODE_W-1:0] next_node;
	logic              ram_we;
	logic              alloc;

	assign nib       = digest_q[DIGEST_W-1 -: NIB_W];
	assign walk_addr = ADDR_W'(nib) * ADDR_W'(POOL_NODES) + ADDR_W'(cur_q);
	assign next_node = used_q + NODE_W'(1);

	assign sts.clr_last   = (clr_q == ADDR_W'(TABLE_DEPTH - 1));
	assign sts.miss       = (ram_rdata == '0);
	assign sts.full       = (used_q == NODE_W'(POOL_NODES - 1));
	assign sts.last_level = (level_q == LVL_W'(DIGEST_NIBBLES - 1));
	assign sts.is_lookup  = (cmd_q == CMD_LOOKUP);
	assign sts.rsp_free   = !rsp_valid_q || !rsp_stall;

	assign alloc     = ctl.eval && sts.miss && !sts.is_lookup && !sts.full;
	assign ram_we    = ctl.clear || alloc;
	assign ram_addr  = ctl.clear ? clr_q : walk_addr;
	assign ram_wdata = ctl.clear ? '0 : next_node;

	dts_ram #(
		.WIDTH(NODE_W),
		.DEPTH(TABLE_DEPTH)
	) u_child_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (alloc) begin
				used_q <= next_node;
			end
			if (ctl.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			digest_q <= {req.digest_high, req.digest_low};
			cmd_q    <= req.command;
			cur_q    <= '0;
			level_q  <= '0;
			hit_q    <= (req.command == CMD_LOOKUP);
			status_q <= STATUS_OK;
		end else begin
			if (ctl.eval) begin
				if (!sts.miss) begin
					cur_q <= ram_rdata;
				end else if (sts.is_lookup) begin
					hit_q <= 1'b0;
				end else if (sts.full) begin
					status_q <= STATUS_FULL;
				end else begin
					cur_q <= next_node;
				end
			end
			if (ctl.advance) begin
				digest_q <= {digest_q[DIGEST_W-NIB_W-1:0], NIB_W'(0)};
				level_q  <= level_q + LVL_W'(1);
			end
		end
		if (ctl.rsp_load) begin
			rsp_q.hit    <= hit_q;
			rsp_q.status <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/dts_ctrl.sv -----
// Controller state machine of the digest trie set.
`timescale 1ns / 1ps
module dts_ctrl import dts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  sts_t sts,
	output logic req_stall,
	output ctl_t ctl
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_EVAL  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stop;

	assign stop = (sts.miss && (sts.is_lookup || sts.full)) || sts.last_level;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:  if (req_valid) state_d = S_READ;
			S_READ:  state_d = S_EVAL;
			S_EVAL:  state_d = stop ? S_DONE : S_READ;
			S_DONE:  if (sts.rsp_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall    = (state_q != S_IDLE);
	assign ctl.clear    = (state_q == S_CLEAR);
	assign ctl.load     = (state_q == S_IDLE) && req_valid;
	assign ctl.eval     = (state_q == S_EVAL);
	assign ctl.advance  = (state_q == S_EVAL) && !stop;
	assign ctl.rsp_load = (state_q == S_DONE) && sts.rsp_free;

endmodule

// ----- rtl/core/digest_trie_set_core.sv -----
// Top level of the digest trie set: controller and datapath.
//
// A request word carries a command (insert or look up) and a 128-bit digest.
// It is taken when req_valid is high and req_stall is low. Each request gives
// exactly one response word (hit, status) on rsp_valid / rsp_stall.
// The digest is walked one nibble per level, most significant first. Each
// level has a read of the child table RAM and then a check of the pointer
// that, on an insert, writes a newly allocated node. A walk ends at the last
// level, or earlier when a lookup misses or an insert finds the node pool
// full; the result is then posted into the output register, and the response
// word shows up in the cycle after that.
// One request is in work at a time; the next is taken in the cycle after the
// result is posted, while it may still wait in the output register.
// After reset the child table is swept to zero, one entry per cycle, over all
// TABLE_DEPTH entries (131072 at the default sizes); req_stall stays high
// during that sweep. While the receiver holds rsp_stall the response stays
// put and a finished walk waits before posting its own result.
`timescale 1ns / 1ps
module digest_trie_set_core import dts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;

	dts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.sts      (sts),
		.req_stall(req_stall),
		.ctl      (ctl)
	);

	dts_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.req      (req),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

// ----- rtl/core/dts_checker.sv -----
// Port-level checks of the digest trie set and their binding to the top level.
`timescale 1ns / 1ps
module dts_checker import dts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("Response word dropped while stalled.");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("Request word changed while stalled.");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Request word taken while another is in work.");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.status))
		else $error("Response word reports both a hit and a full pool.");

	a_post_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("Response word posted without a request in work.");

endmodule

bind digest_trie_set_core dts_checker u_dts_checker (.*);

// ----- test/tb_digest_trie_set_core.sv -----
// Self-checking testbench for digest_trie_set_core: fixed and random inserts and lookups checked by a trie predictor.
`timescale 1ns / 1ps
module tb_digest_trie_set_core;
	import dts_pkg::*;

	class digest_set_scoreboard;
		bit [NODE_W-1:0] child_ptr [TABLE_DEPTH];
		int unsigned alloc_count;
		rsp_t owed_answers [$];
		int fail_count;

		function rsp_t walk_digest(req_t item);
			logic [DIGEST_W-1:0] key;
			int unsigned node;
			int unsigned slot;
			rsp_t res;
			key = {item.digest_high, item.digest_low};
			node = 0;
			res.hit = (item.command == CMD_LOOKUP);
			res.status = STATUS_OK;
			for (int lvl = 0; lvl < DIGEST_NIBBLES; lvl++) begin
				slot = key[DIGEST_W-1-NIB_W*lvl -: NIB_W] * POOL_NODES + node;
				if (child_ptr[slot] == 0) begin
					if (item.command == CMD_LOOKUP) begin
						res.hit = 1'b0;
						break;
					end
					if (alloc_count + 1 >= POOL_NODES) begin
						res.status = STATUS_FULL;
						break;
					end
					alloc_count++;
					child_ptr[slot] = NODE_W'(alloc_count);
				end
				node = 32'(child_ptr[slot]);
			end
			return res;
		endfunction

		function void note_request(req_t item);
			owed_answers = {owed_answers, walk_digest(item)};
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (owed_answers.size() == 0) begin
				$error("unexpected response word: hit %0b status %0b", got.hit, got.status);
				fail_count++;
				return;
			end
			want = owed_answers.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0b, actual %0b", want.hit, got.hit);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0b, actual %0b", want.status, got.status);
				fail_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	digest_set_scoreboard sb;
	logic [DIGEST_W-1:0] known_digests [$];
	int send_idle_pct;
	int stall_pct;
	bit hold_ask;
	int hold_left;

	digest_trie_set_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (hold_ask) begin
			hold_left = 400;
			hold_ask = 1'b0;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			sb.check_response(rsp);
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic req_t make_item(logic cmd, logic [DIGEST_W-1:0] digest);
		return req_t'({cmd, digest});
	endfunction

	function automatic logic [DIGEST_W-1:0] random_digest();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [DIGEST_W-1:0] nudge(logic [DIGEST_W-1:0] digest);
		int lvl;
		lvl = $urandom_range(DIGEST_NIBBLES - 1);
		digest[DIGEST_W-1-NIB_W*lvl -: NIB_W] =
			digest[DIGEST_W-1-NIB_W*lvl -: NIB_W] ^ NIB_W'($urandom_range(RADIX - 1, 1));
		return digest;
	endfunction

	function automatic logic [DIGEST_W-1:0] pick_known();
		return known_digests[$urandom_range(known_digests.size() - 1)];
	endfunction

	task automatic offer(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
		if (item.command == CMD_INSERT) begin
			known_digests = {known_digests, {item.digest_high, item.digest_low}};
		end
	endtask

	task automatic wait_all_answered();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.owed_answers.size() != 0);
	endtask

	task automatic run_phase(input int idle, input int stall, input int count, input bit long_hold);
		int pick;
		logic [DIGEST_W-1:0] digest;
		send_idle_pct = idle;
		stall_pct = stall;
		if (long_hold) begin
			hold_ask = 1'b1;
		end
		for (int n = 0; n < count; n++) begin
			pick = (known_digests.size() == 0) ? 0 : $urandom_range(99);
			if (pick < 25) begin
				offer(make_item(CMD_INSERT, random_digest()));
			end else if (pick < 35) begin
				offer(make_item(CMD_INSERT, pick_known()));
			end else if (pick < 45) begin
				offer(make_item(CMD_INSERT, nudge(pick_known())));
			end else if (pick < 70) begin
				offer(make_item(CMD_LOOKUP, pick_known()));
			end else if (pick < 90) begin
				offer(make_item(CMD_LOOKUP, nudge(pick_known())));
			end else if (pick < 95) begin
				offer(make_item(CMD_LOOKUP, random_digest()));
			end else begin
				digest = {DIGEST_NIBBLES{NIB_W'($urandom_range(RADIX - 1))}};
				offer(make_item(logic'($urandom_range(1)), digest));
			end
		end
		wait_all_answered();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_ask = 1'b0;
		hold_left = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		offer(make_item(CMD_LOOKUP, '0));
		offer(make_item(CMD_INSERT, '0));
		offer(make_item(CMD_LOOKUP, '0));
		offer(make_item(CMD_INSERT, '0));
		offer(make_item(CMD_INSERT, '1));
		offer(make_item(CMD_LOOKUP, '1));
		offer(make_item(CMD_LOOKUP, {{(DIGEST_W-1){1'b1}}, 1'b0}));
		offer(make_item(CMD_LOOKUP, {{(DIGEST_W/2){1'b1}}, {(DIGEST_W/2){1'b0}}}));
		offer(make_item(CMD_INSERT, 128'h1));
		offer(make_item(CMD_LOOKUP, 128'h1));
		offer(make_item(CMD_LOOKUP, 128'h2));
		offer(make_item(CMD_INSERT, 128'h0123456789abcdef_fedcba9876543210));
		offer(make_item(CMD_LOOKUP, 128'h0123456789abcdef_fedcba9876543210));
		offer(make_item(CMD_INSERT, {(DIGEST_W/4){4'h5}}));
		offer(make_item(CMD_LOOKUP, {(DIGEST_W/4){4'ha}}));
		offer(make_item(CMD_LOOKUP, {4'h1, {(DIGEST_W-4){1'b0}}}));
		offer(make_item(CMD_LOOKUP, {(DIGEST_W/4){4'h5}}));
		wait_all_answered();

		run_phase(0, 0, 260, 1'b1);
		run_phase(61, 0, 260, 1'b0);
		run_phase(0, 61, 260, 1'b0);
		run_phase(35, 35, 260, 1'b0);
		run_phase(0, 0, 260, 1'b0);

		repeat (70) @(posedge clk);
		if (sb.fail_count == 0 && sb.owed_answers.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
